// ===== src/skrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted keyed record table package
// Shared widths, sizes, request codes and status codes.
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned MAX_RESULTS = 32;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned GRADE_W = 16;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
  } entry_t;

endpackage

// ===== src/skrt_if.sv =====
// ----------------------------------------------------------------------------
// Sorted keyed record table channels
// Valid/ready channels for requests and for result records.
// ----------------------------------------------------------------------------
interface skrt_req_if;
  logic                        valid;
  logic                        ready;
  logic [skrt_pkg::CMD_W-1:0]   cmd;
  logic [skrt_pkg::KEY_W-1:0]   key;
  logic [skrt_pkg::GRADE_W-1:0] grade;

  modport source (output valid, cmd, key, grade, input ready);
  modport sink   (input valid, cmd, key, grade, output ready);
endinterface

interface skrt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [skrt_pkg::STAT_W-1:0]  status;
  logic [skrt_pkg::KEY_W-1:0]   rec_key;
  logic [skrt_pkg::GRADE_W-1:0] rec_grade;
  logic                        last;

  modport source (output valid, status, rec_key, rec_grade, last, input ready);
  modport sink   (input valid, status, rec_key, rec_grade, last, output ready);
endinterface

// ===== src/sorted_keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// Sorted keyed record table
// Keeps up to CAPACITY key/grade records in ascending key order in one
// synchronous memory. A request inserts, removes, finds or lists records.
//
// The request channel req_i takes one request when the block is idle. Every
// request produces one or more result records on rsp_o; the final one of a
// request has last set. Find and list give one record per matching entry.
// Each request walks the stored entries with one memory read per cycle while
// no stalled receiver holds the walk: insert walks down from the top,
// shifting entries up until the new key fits; remove walks up, shifting
// entries down behind the removed one; find and list walk up and send
// records as they go. The next request is taken in the cycle after the
// final result of a request is loaded. A full insert, or a remove, find
// or list on an empty table, skips the walk and goes straight to its
// result.
// The result register parts the two channels: a stalled receiver only holds
// back a find or list walk when the next record is ready to go out.
// Reset empties the table at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  skrt_req_if.sink           req_i,
  skrt_rsp_if.source         rsp_o
);
  import skrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  entry_t mem [CAPACITY];
  entry_t rd_q;

  logic    mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t  mem_wd;

  state_e  state_q, state_d;
  cmd_e    op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [GRADE_W-1:0] grade_q, grade_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q, left_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          found_q, found_d;
  logic [NW-1:0] nmatch_q, nmatch_d;
  logic          res_vld_q, res_vld_d;
  status_e       res_status_q, res_status_d;
  entry_t        res_q, res_d;
  logic          out_vld_q, out_vld_d;
  status_e       out_status_q, out_status_d;
  entry_t        out_q, out_d;
  logic          out_last_q, out_last_d;

  logic can_push, is_srch, match, scan_end, stall, consume, issue;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign can_push = !out_vld_q || rsp_o.ready;
  assign is_srch  = (op_q == CMD_FIND) || (op_q == CMD_LIST);
  assign match    = (op_q == CMD_LIST) || (rd_q.key == key_q);
  assign scan_end = ((left_q == '0) && !rd_pend_q) ||
                    (is_srch && (nmatch_q == NW'(MAX_RESULTS)));
  assign stall    = is_srch && match && res_vld_q && !can_push;
  assign consume  = (state_q == S_SCAN) && !scan_end && rd_pend_q && !stall;
  assign issue    = (state_q == S_SCAN) && !scan_end && (left_q != '0) &&
                    (!rd_pend_q || consume);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    grade_d      = grade_q;
    count_d      = count_q;
    left_d       = left_q;
    addr_d       = addr_q;
    rd_idx_d     = rd_idx_q;
    rd_pend_d    = rd_pend_q;
    found_d      = found_q;
    nmatch_d     = nmatch_q;
    res_vld_d    = res_vld_q;
    res_status_d = res_status_q;
    res_d        = res_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = rd_q;
    mem_re       = 1'b0;
    mem_ra       = addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d      = cmd_e'(req_i.cmd);
          key_d     = req_i.key;
          grade_d   = req_i.grade;
          rd_pend_d = 1'b0;
          found_d   = 1'b0;
          nmatch_d  = '0;
          res_vld_d = 1'b0;
          res_d     = '0;
          left_d    = count_q;
          if (cmd_e'(req_i.cmd) == CMD_INSERT) begin
            addr_d = count_q[AW-1:0] - AW'(1);
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            addr_d = '0;
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          state_d = S_DONE;
          unique case (op_q)
            CMD_INSERT: begin
              mem_we       = 1'b1;
              mem_wa       = '0;
              mem_wd       = '{key: key_q, grade: grade_q};
              count_d      = count_q + CW'(1);
              res_status_d = ST_OK;
              res_d        = '{key: key_q, grade: grade_q};
            end
            CMD_REMOVE: begin
              if (found_q) begin
                count_d      = count_q - CW'(1);
                res_status_d = ST_OK;
              end else begin
                res_status_d = ST_NOTFOUND;
                res_d        = '0;
              end
            end
            CMD_FIND, CMD_LIST: begin
              if (res_vld_q) begin
                res_status_d = ST_OK;
              end else begin
                res_status_d = ST_NOTFOUND;
                res_d        = '0;
              end
            end
            default: ;
          endcase
        end else begin
          if (consume) begin
            rd_pend_d = 1'b0;
            unique case (op_q)
              CMD_INSERT: begin
                mem_we = 1'b1;
                mem_wa = rd_idx_q + AW'(1);
                if (rd_q.key < key_q) begin
                  mem_wd       = '{key: key_q, grade: grade_q};
                  count_d      = count_q + CW'(1);
                  res_status_d = ST_OK;
                  res_d        = '{key: key_q, grade: grade_q};
                  state_d      = S_DONE;
                end
              end
              CMD_REMOVE: begin
                if (found_q) begin
                  mem_we = 1'b1;
                  mem_wa = rd_idx_q - AW'(1);
                end else if (rd_q.key == key_q) begin
                  found_d = 1'b1;
                  res_d   = rd_q;
                end
              end
              CMD_FIND, CMD_LIST: begin
                if (match) begin
                  if (res_vld_q) begin
                    out_vld_d    = 1'b1;
                    out_status_d = ST_OK;
                    out_d        = res_q;
                    out_last_d   = 1'b0;
                  end
                  res_d     = rd_q;
                  res_vld_d = 1'b1;
                  nmatch_d  = nmatch_q + NW'(1);
                end
              end
              default: ;
            endcase
          end
          if (issue) begin
            mem_re    = 1'b1;
            mem_ra    = addr_q;
            rd_idx_d  = addr_q;
            rd_pend_d = 1'b1;
            left_d    = left_q - CW'(1);
            addr_d    = (op_q == CMD_INSERT) ? addr_q - AW'(1) : addr_q + AW'(1);
          end
        end
      end

      S_DONE: begin
        if (can_push) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_d        = res_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      nmatch_q  <= '0;
      res_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      left_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_pend_q <= rd_pend_d;
      found_q   <= found_d;
      nmatch_q  <= nmatch_d;
      res_vld_q <= res_vld_d;
      out_vld_q <= out_vld_d;
      left_q    <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    grade_q      <= grade_d;
    addr_q       <= addr_d;
    rd_idx_q     <= rd_idx_d;
    res_status_q <= res_status_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_q        <= out_d;
    out_last_q   <= out_last_d;
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.rec_key   = out_q.key;
  assign rsp_o.rec_grade = out_q.grade;
  assign rsp_o.last      = out_last_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted keyed record table testbench
// Drives insert, remove, find and list requests into the table and checks
// every result record against a tracked copy of the sorted table. A directed
// opening covers the empty, missing-key, duplicate-key and extreme-value cases.
// Random phases then fill the table to capacity, drain it and mix requests,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skrt_pkg::*;

  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned PHASE_ITEMS = 40;
  localparam int unsigned POOL_SIZE   = 8;

  typedef struct {
    status_e            status;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
    logic               last;
  } record_t;

  class sorted_table_tracker;
    entry_t      rows[CAPACITY];
    int unsigned row_count;
    record_t     expected_records[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned peak;
    int unsigned kind_count[4];
    int unsigned full_refusals;
    int unsigned empty_replies;
    int unsigned miss_replies;

    function new();
      row_count     = 0;
      errors        = 0;
      checked       = 0;
      peak          = 0;
      full_refusals = 0;
      empty_replies = 0;
      miss_replies  = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_records.size();
    endfunction

    function void push(status_e st, logic [KEY_W-1:0] k, logic [GRADE_W-1:0] g, logic l);
      record_t r;
      r.status = st;
      r.key    = k;
      r.grade  = g;
      r.last   = l;
      expected_records.push_back(r);
    endfunction

    function void note_request(cmd_e cmd, logic [KEY_W-1:0] key, logic [GRADE_W-1:0] grade);
      int unsigned pos;
      int          i;
      int unsigned hits[$];
      kind_count[cmd]++;
      if (cmd == CMD_INSERT) begin
        if (row_count >= CAPACITY) begin
          push(ST_FULL, '0, '0, 1'b1);
          full_refusals++;
        end else begin
          pos = 0;
          while (pos < row_count && rows[pos].key < key) pos++;
          for (i = row_count; i > int'(pos); i--) rows[i] = rows[i-1];
          rows[pos].key   = key;
          rows[pos].grade = grade;
          row_count++;
          if (row_count > peak) peak = row_count;
          push(ST_OK, key, grade, 1'b1);
        end
      end else if (row_count == 0) begin
        push(ST_EMPTY, '0, '0, 1'b1);
        empty_replies++;
      end else if (cmd == CMD_REMOVE) begin
        pos = 0;
        while (pos < row_count && rows[pos].key != key) pos++;
        if (pos >= row_count) begin
          push(ST_NOTFOUND, '0, '0, 1'b1);
          miss_replies++;
        end else begin
          push(ST_OK, rows[pos].key, rows[pos].grade, 1'b1);
          for (i = pos; i + 1 < int'(row_count); i++) rows[i] = rows[i+1];
          row_count--;
        end
      end else begin
        for (i = 0; i < int'(row_count) && hits.size() < MAX_RESULTS; i++) begin
          if (cmd == CMD_LIST || rows[i].key == key) hits.push_back(i);
        end
        if (hits.size() == 0) begin
          push(ST_NOTFOUND, '0, '0, 1'b1);
          miss_replies++;
        end else begin
          foreach (hits[j]) begin
            push(ST_OK, rows[hits[j]].key, rows[hits[j]].grade, j == hits.size() - 1);
          end
        end
      end
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [KEY_W-1:0] k,
                               logic [GRADE_W-1:0] g, logic l);
      record_t exp;
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected result status=%0d key=%h grade=%h last=%b",
                 $time, st, k, g, l);
        errors++;
        return;
      end
      exp = expected_records.pop_front();
      checked++;
      if (exp.status !== st) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, st);
        errors++;
      end
      if (exp.key !== k) begin
        $display("%0t: rec_key expected %h actual %h", $time, exp.key, k);
        errors++;
      end
      if (exp.grade !== g) begin
        $display("%0t: rec_grade expected %h actual %h", $time, exp.grade, g);
        errors++;
      end
      if (exp.last !== l) begin
        $display("%0t: last expected %b actual %b", $time, exp.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  skrt_req_if req_if ();
  skrt_rsp_if rsp_if ();

  sorted_keyed_record_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sorted_table_tracker table_track;
  logic [KEY_W-1:0]    key_pool[POOL_SIZE];
  bit                  steady;
  bit                  hold_rsp_request;
  int unsigned         hold_left;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = '0;
    req_if.key       = '0;
    req_if.grade     = '0;
    rsp_if.ready     = 1'b0;
    steady           = 1'b0;
    hold_rsp_request = 1'b0;
    hold_left        = 0;
    table_track      = new();
  end

  initial begin
    #(2_000_000);
    $display("Timeout with %0d results outstanding.", table_track.pending());
    $display("** sorted_keyed_record_table: FAILED **");
    $finish;
  end

  initial begin
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        table_track.check_result(rsp_if.status, rsp_if.rec_key, rsp_if.rec_grade, rsp_if.last);
      end
      if (hold_rsp_request) begin
        hold_rsp_request = 1'b0;
        hold_left        = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_request(cmd_e cmd, logic [KEY_W-1:0] key, logic [GRADE_W-1:0] grade);
    while (!steady && $urandom_range(99) < 16) begin
      req_if.valid <= 1'b0;
      req_if.cmd   <= CMD_W'($urandom);
      req_if.key   <= KEY_W'($urandom);
      req_if.grade <= GRADE_W'($urandom);
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= cmd;
    req_if.key   <= key;
    req_if.grade <= grade;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    table_track.note_request(cmd, key, grade);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (table_track.pending() != 0) @(posedge clk_i);
  endtask

  function automatic cmd_e pick_cmd(int unsigned p_ins, int unsigned p_rem, int unsigned p_find);
    int unsigned r;
    r = $urandom_range(99);
    if (r < p_ins) return CMD_INSERT;
    if (r < p_ins + p_rem) return CMD_REMOVE;
    if (r < p_ins + p_rem + p_find) return CMD_FIND;
    return CMD_LIST;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(cmd_e cmd);
    if (cmd != CMD_INSERT && table_track.row_count > 0 && $urandom_range(1) == 1) begin
      return table_track.rows[$urandom_range(table_track.row_count - 1)].key;
    end
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return KEY_W'($urandom);
  endfunction

  initial begin
    cmd_e        cmd;
    int unsigned p_ins;
    int unsigned p_rem;
    int unsigned p_find;
    logic [KEY_W-1:0] kmax;

    kmax        = '1;
    key_pool[0] = '0;
    key_pool[1] = kmax;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_LIST,   '0, '0);
    send_request(CMD_FIND,   31'd5, 16'hFFFF);
    send_request(CMD_REMOVE, 31'd5, 16'hFFFF);
    send_request(CMD_INSERT, kmax, 16'hFFFF);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, kmax, 16'h00FF);
    send_request(CMD_INSERT, 31'h2AAAAAAA, 16'hAAAA);
    send_request(CMD_INSERT, 31'h55555555, 16'h5555);
    send_request(CMD_FIND,   kmax, '0);
    send_request(CMD_FIND,   31'h1234, '0);
    send_request(CMD_LIST,   '0, '0);
    send_request(CMD_REMOVE, 31'h1234, '0);
    send_request(CMD_REMOVE, kmax, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_LIST,   kmax, 16'hFFFF);
    send_request(CMD_REMOVE, 31'h2AAAAAAA, '0);
    send_request(CMD_REMOVE, 31'h55555555, '0);
    send_request(CMD_REMOVE, kmax, '0);
    send_request(CMD_REMOVE, kmax, '0);
    send_request(CMD_INSERT, 31'd1, 16'd1);
    send_request(CMD_FIND,   31'd1, '0);
    wait_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0, 2: begin
          p_ins = 88; p_rem = 4;  p_find = 4;
        end
        1: begin
          p_ins = 15; p_rem = 65; p_find = 12;
        end
        default: begin
          p_ins = 40; p_rem = 35; p_find = 15;
        end
      endcase
      steady = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 10) hold_rsp_request = 1'b1;
        cmd = pick_cmd(p_ins, p_rem, p_find);
        send_request(cmd, pick_key(cmd), GRADE_W'($urandom));
      end
      send_request(CMD_LIST, KEY_W'($urandom), GRADE_W'($urandom));
      wait_results_drained();
    end
    steady = 1'b0;

    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Covered %0d inserts, %0d removes, %0d finds and %0d lists; %0d results checked.",
             table_track.kind_count[CMD_INSERT], table_track.kind_count[CMD_REMOVE],
             table_track.kind_count[CMD_FIND], table_track.kind_count[CMD_LIST],
             table_track.checked);
    $display("Peak fill %0d of %0d, %0d refused inserts, %0d empty and %0d not-found replies.",
             table_track.peak, CAPACITY, table_track.full_refusals,
             table_track.empty_replies, table_track.miss_replies);
    if (table_track.errors == 0 && table_track.pending() == 0) begin
      $display("** sorted_keyed_record_table: PASSED **");
    end else begin
      $display("** sorted_keyed_record_table: FAILED **");
    end
    $finish;
  end

endmodule
